// ----- design/kst_pkg.sv -----
package kst_pkg;

   localparam int MODE_W   = 3;
   localparam int OWNER_W  = 8;
   localparam int VAR_W    = 32;
   localparam int WORD_W   = 32;
   localparam int KIND_W   = 16;
   localparam int SIDX_W   = 6;
   localparam int STATUS_W = 3;
   localparam int MCNT_W   = 7;

   localparam logic [MODE_W-1:0] MODE_INSERT = 3'd0;
   localparam logic [MODE_W-1:0] MODE_LOOKUP = 3'd1;
   localparam logic [MODE_W-1:0] MODE_FIRST  = 3'd2;
   localparam logic [MODE_W-1:0] MODE_FREE   = 3'd3;
   localparam logic [MODE_W-1:0] MODE_COUNT  = 3'd4;

   localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd1;
   localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
   localparam logic [STATUS_W-1:0] ST_REJECT    = 3'd3;
   localparam logic [STATUS_W-1:0] ST_BAD_SLOT  = 3'd4;

   typedef struct packed {
      logic [OWNER_W-1:0] owner;
      logic [VAR_W-1:0]   var_id;
      logic [WORD_W-1:0]  word_a;
      logic [WORD_W-1:0]  word_b;
      logic [KIND_W-1:0]  kind;
   } entry_type;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      entry_type         entry;
      logic [SIDX_W-1:0] slot_index;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [SIDX_W-1:0]   slot_out;
      entry_type           entry;
      logic [MCNT_W-1:0]   match_count;
   } rsp_type;

   typedef struct packed {
      logic empty;
      logic owner_eq;
      logic key_eq;
   } match_type;

   typedef enum logic [2:0] {
      SEQ_CLEAR,
      SEQ_IDLE,
      SEQ_SCAN,
      SEQ_FREE_RD,
      SEQ_FREE_WR,
      SEQ_RESULT
   } seq_state_type;

endpackage

// ----- design/kst_if.sv -----
interface kst_req_if import kst_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [MODE_W-1:0]   mode;
   logic [OWNER_W-1:0]  owner_id;
   logic [VAR_W-1:0]    var_id;
   logic signed [WORD_W-1:0] word_a;
   logic signed [WORD_W-1:0] word_b;
   logic [KIND_W-1:0]   kind;
   logic [SIDX_W-1:0]   slot_index;

   modport source (output valid, mode, owner_id, var_id, word_a, word_b, kind, slot_index,
                   input ready);
   modport sink   (input valid, mode, owner_id, var_id, word_a, word_b, kind, slot_index,
                   output ready);
endinterface

interface kst_rsp_if import kst_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [SIDX_W-1:0]   slot_out;
   logic [OWNER_W-1:0]  owner_out;
   logic [VAR_W-1:0]    var_out;
   logic signed [WORD_W-1:0] word_a_out;
   logic signed [WORD_W-1:0] word_b_out;
   logic [KIND_W-1:0]   kind_out;
   logic [MCNT_W-1:0]   match_count;

   modport source (output valid, status, slot_out, owner_out, var_out, word_a_out,
                   word_b_out, kind_out, match_count,
                   input ready);
   modport sink   (input valid, status, slot_out, owner_out, var_out, word_a_out,
                   word_b_out, kind_out, match_count,
                   output ready);
endinterface

// ----- design/keyed_slot_table_unit.sv -----
// Slot table of SLOT_COUNT entries held in one single-port-read RAM, walked by a
// small sequencer that reads one slot per cycle through a shared compare unit.
// Insert, lookup and first-of-owner stop at the first hit; a miss, a full table
// and a count scan every slot; a free reads its slot and then writes it to zero;
// a rejected request or an out-of-range free goes straight to the result state.
// One request is in flight at a time, and a new one may be taken while the
// previous result still waits in the output register. After reset a clearing
// pass writes zero to every slot, one per cycle, with req ready held low.
module keyed_slot_table_unit import kst_pkg::*; #(
   parameter int SLOT_COUNT = 64
) (
   input  logic      clock,
   input  logic      reset,
   kst_req_if.sink   req_bus,
   kst_rsp_if.source rsp_bus
);

   localparam int IDX_W = $clog2(SLOT_COUNT);
   localparam int CNT_W = $clog2(SLOT_COUNT + 1);
   localparam int SXW   = (IDX_W > SIDX_W) ? IDX_W : SIDX_W;
   localparam int CXW   = (CNT_W > MCNT_W) ? CNT_W : MCNT_W;
   localparam logic [IDX_W-1:0] LAST = IDX_W'(SLOT_COUNT - 1);

   seq_state_type    state_ff, state_in;
   logic [IDX_W-1:0] addr_ff, addr_in;
   logic [IDX_W-1:0] rd_idx_ff, rd_idx_in;
   logic             rd_pend_ff, rd_pend_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   req_type          req_ff, req_in;
   rsp_type          res_ff, res_in;
   rsp_type          out_ff, out_in;
   logic             out_valid_ff, out_valid_in;

   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   entry_type        wr_data;
   entry_type        rd_data;
   match_type        match;
   logic             accept;
   logic             hit;
   logic [SXW-1:0]   sidx_ext;
   logic [SXW-1:0]   slot_ext;
   logic [CNT_W-1:0] cnt_next;
   logic [CXW-1:0]   cnt_ext;

   kst_ram #(
      .WIDTH ($bits(entry_type)),
      .DEPTH (SLOT_COUNT)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (addr_ff),
      .rd_data (rd_data)
   );

   kst_match u_match (
      .entry  (rd_data),
      .owner  (req_ff.entry.owner),
      .var_id (req_ff.entry.var_id),
      .match  (match)
   );

   assign accept   = req_bus.valid && req_bus.ready;
   assign sidx_ext = SXW'(req_bus.slot_index);
   assign cnt_next = cnt_ff + CNT_W'(match.owner_eq);
   assign cnt_ext  = CXW'(cnt_next);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= SEQ_CLEAR;
         addr_ff      <= '0;
         rd_pend_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         addr_ff      <= addr_in;
         rd_pend_ff   <= rd_pend_in;
         out_valid_ff <= out_valid_in;
      end
      rd_idx_ff <= rd_idx_in;
      cnt_ff    <= cnt_in;
      req_ff    <= req_in;
      res_ff    <= res_in;
      out_ff    <= out_in;
   end

   always_comb begin
      state_in     = state_ff;
      addr_in      = addr_ff;
      rd_idx_in    = rd_idx_ff;
      rd_pend_in   = rd_pend_ff;
      cnt_in       = cnt_ff;
      req_in       = req_ff;
      res_in       = res_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff;
      wr_en        = 1'b0;
      wr_addr      = addr_ff;
      wr_data      = '0;
      hit          = 1'b0;
      slot_ext     = SXW'(rd_idx_ff);
      req_bus.ready = (state_ff == SEQ_IDLE);

      if (rsp_bus.ready) begin
         out_valid_in = 1'b0;
      end

      case (state_ff)
         SEQ_CLEAR: begin
            wr_en = 1'b1;
            if (addr_ff == LAST) begin
               addr_in  = '0;
               state_in = SEQ_IDLE;
            end else begin
               addr_in = addr_ff + IDX_W'(1);
            end
         end
         SEQ_IDLE: begin
            if (accept) begin
               req_in.mode         = req_bus.mode;
               req_in.entry.owner  = req_bus.owner_id;
               req_in.entry.var_id = req_bus.var_id;
               req_in.entry.word_a = req_bus.word_a;
               req_in.entry.word_b = req_bus.word_b;
               req_in.entry.kind   = req_bus.kind;
               req_in.slot_index   = req_bus.slot_index;
               res_in     = '0;
               cnt_in     = '0;
               rd_pend_in = 1'b0;
               addr_in    = '0;
               case (req_bus.mode)
                  MODE_INSERT: begin
                     if ((req_bus.var_id == '0) || (req_bus.kind == '0)) begin
                        res_in.status = ST_REJECT;
                        state_in      = SEQ_RESULT;
                     end else begin
                        state_in = SEQ_SCAN;
                     end
                  end
                  MODE_LOOKUP, MODE_FIRST, MODE_COUNT: begin
                     state_in = SEQ_SCAN;
                  end
                  MODE_FREE: begin
                     if (32'(req_bus.slot_index) >= 32'(SLOT_COUNT)) begin
                        res_in.status = ST_BAD_SLOT;
                        state_in      = SEQ_RESULT;
                     end else begin
                        addr_in  = sidx_ext[IDX_W-1:0];
                        state_in = SEQ_FREE_RD;
                     end
                  end
                  default: begin
                     res_in.status = ST_REJECT;
                     state_in      = SEQ_RESULT;
                  end
               endcase
            end
         end
         SEQ_SCAN: begin
            rd_pend_in = 1'b1;
            rd_idx_in  = addr_ff;
            if (addr_ff != LAST) begin
               addr_in = addr_ff + IDX_W'(1);
            end
            if (rd_pend_ff) begin
               case (req_ff.mode)
                  MODE_INSERT: hit = match.empty;
                  MODE_LOOKUP: hit = match.key_eq;
                  MODE_FIRST:  hit = match.owner_eq;
                  default:     hit = 1'b0;
               endcase
               cnt_in = cnt_next;
               if (hit) begin
                  res_in.status   = ST_OK;
                  res_in.slot_out = slot_ext[SIDX_W-1:0];
                  if (req_ff.mode == MODE_INSERT) begin
                     wr_en        = 1'b1;
                     wr_addr      = rd_idx_ff;
                     wr_data      = req_ff.entry;
                     res_in.entry = req_ff.entry;
                  end else begin
                     res_in.entry = rd_data;
                  end
                  state_in = SEQ_RESULT;
               end else if (rd_idx_ff == LAST) begin
                  case (req_ff.mode)
                     MODE_COUNT: begin
                        res_in.status      = ST_OK;
                        res_in.match_count = cnt_ext[MCNT_W-1:0];
                     end
                     MODE_INSERT: res_in.status = ST_FULL;
                     default:     res_in.status = ST_NOT_FOUND;
                  endcase
                  state_in = SEQ_RESULT;
               end
            end
         end
         SEQ_FREE_RD: begin
            state_in = SEQ_FREE_WR;
         end
         SEQ_FREE_WR: begin
            slot_ext        = SXW'(addr_ff);
            res_in.status   = ST_OK;
            res_in.slot_out = slot_ext[SIDX_W-1:0];
            res_in.entry    = rd_data;
            wr_en           = 1'b1;
            state_in        = SEQ_RESULT;
         end
         SEQ_RESULT: begin
            if (!out_valid_ff || rsp_bus.ready) begin
               out_in       = res_ff;
               out_valid_in = 1'b1;
               state_in     = SEQ_IDLE;
            end
         end
         default: begin
            state_in = SEQ_IDLE;
         end
      endcase
   end

   assign rsp_bus.valid       = out_valid_ff;
   assign rsp_bus.status      = out_ff.status;
   assign rsp_bus.slot_out    = out_ff.slot_out;
   assign rsp_bus.owner_out   = out_ff.entry.owner;
   assign rsp_bus.var_out     = out_ff.entry.var_id;
   assign rsp_bus.word_a_out  = $signed(out_ff.entry.word_a);
   assign rsp_bus.word_b_out  = $signed(out_ff.entry.word_b);
   assign rsp_bus.kind_out    = out_ff.entry.kind;
   assign rsp_bus.match_count = out_ff.match_count;

   a_busy_after_beat: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_bus.ready)
      else $error("request taken while a request is in flight");

   a_error_fields_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && (rsp_bus.status != ST_OK)) |->
         ((rsp_bus.slot_out == '0) && (rsp_bus.var_out == '0) &&
          (rsp_bus.kind_out == '0) && (rsp_bus.match_count == '0)))
      else $error("error result carries entry data");

   a_insert_nonempty: assert property (@(posedge clock) disable iff (reset)
      (wr_en && (state_ff == SEQ_SCAN)) |->
         ((wr_data.var_id != '0) && (wr_data.kind != '0)))
      else $error("insert writes an empty entry");

   a_write_states: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> ((state_ff == SEQ_CLEAR) || (state_ff == SEQ_SCAN) ||
                 (state_ff == SEQ_FREE_WR)))
      else $error("table write outside clear, insert or free");

   a_result_slot_free: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == SEQ_RESULT) && out_valid_ff && !rsp_bus.ready) |=>
         (state_ff == SEQ_RESULT))
      else $error("result overwrote a pending beat");

endmodule

// ----- design/kst_ram.sv -----
module kst_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/kst_match.sv -----
module kst_match import kst_pkg::*; (
   input  entry_type          entry,
   input  logic [OWNER_W-1:0] owner,
   input  logic [VAR_W-1:0]   var_id,
   output match_type          match
);

   always_comb begin
      match.empty    = (entry.owner == '0) && (entry.var_id == '0);
      match.owner_eq = (entry.owner == owner);
      match.key_eq   = (entry.owner == owner) && (entry.var_id == var_id);
   end

endmodule

// ----- verif/kst_table_checker.sv -----
`timescale 1ns / 100ps

module kst_table_checker import kst_pkg::*; #(
   parameter int SLOT_COUNT = 64
) (
   input  logic clock,
   input  logic reset,
   kst_req_if   req_mon,
   kst_rsp_if   rsp_mon,
   output int   fail_count,
   output int   results_owed
);

   entry_type slots [SLOT_COUNT];
   rsp_type   owed_results [$];
   int        beat_num;

   initial begin
      fail_count   = 0;
      results_owed = 0;
      beat_num     = 0;
   end

   task report_mismatch(input string what, input logic [31:0] got, input logic [31:0] want);
      $display("t=%0t beat %0d %s: got %h want %h", $time, beat_num, what, got, want);
      fail_count++;
   endtask

   // lowest slot whose owner (and var id, if asked) matches, -1 on a miss
   function automatic int find_slot(input logic [OWNER_W-1:0] owner,
                                    input logic [VAR_W-1:0] var_id, input bit need_var);
      for (int i = 0; i < SLOT_COUNT; i++) begin
         if (slots[i].owner == owner && (!need_var || slots[i].var_id == var_id))
            return i;
      end
      return -1;
   endfunction

   function automatic rsp_type table_apply(input logic [MODE_W-1:0] mode,
                                           input entry_type req_e,
                                           input logic [SIDX_W-1:0] sidx);
      rsp_type r;
      int      hit;
      int      cnt;
      r   = '0;
      hit = -1;
      cnt = 0;
      case (mode)
         MODE_INSERT: begin
            if (req_e.var_id == '0 || req_e.kind == '0) begin
               r.status = ST_REJECT;
            end else begin
               hit = find_slot('0, '0, 1'b1);
               if (hit < 0) begin
                  r.status = ST_FULL;
               end else begin
                  slots[hit] = req_e;
                  r.status   = ST_OK;
                  r.slot_out = SIDX_W'(hit);
                  r.entry    = req_e;
               end
            end
         end
         MODE_LOOKUP, MODE_FIRST: begin
            hit = find_slot(req_e.owner, req_e.var_id, mode == MODE_LOOKUP);
            if (hit < 0) begin
               r.status = ST_NOT_FOUND;
            end else begin
               r.status   = ST_OK;
               r.slot_out = SIDX_W'(hit);
               r.entry    = slots[hit];
            end
         end
         MODE_FREE: begin
            if (int'(sidx) >= SLOT_COUNT) begin
               r.status = ST_BAD_SLOT;
            end else begin
               r.status    = ST_OK;
               r.slot_out  = sidx;
               r.entry     = slots[sidx];
               slots[sidx] = '0;
            end
         end
         MODE_COUNT: begin
            for (int i = 0; i < SLOT_COUNT; i++)
               if (slots[i].owner == req_e.owner) cnt++;
            r.status      = ST_OK;
            r.match_count = MCNT_W'(cnt);
         end
         default: begin
            r.status = ST_REJECT;
         end
      endcase
      return r;
   endfunction

   always @(posedge clock) begin
      rsp_type   want;
      entry_type req_e;
      if (reset) begin
         for (int i = 0; i < SLOT_COUNT; i++) slots[i] = '0;
         owed_results.delete();
      end else begin
         // result first: a request beat in the same cycle is never its source
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (owed_results.size() == 0) begin
               report_mismatch("unexpected result, status", 32'(rsp_mon.status), '0);
            end else begin
               want = owed_results.pop_front();
               if (rsp_mon.status !== want.status)
                  report_mismatch("status", 32'(rsp_mon.status), 32'(want.status));
               if (rsp_mon.slot_out !== want.slot_out)
                  report_mismatch("slot_out", 32'(rsp_mon.slot_out), 32'(want.slot_out));
               if (rsp_mon.owner_out !== want.entry.owner)
                  report_mismatch("owner_out", 32'(rsp_mon.owner_out), 32'(want.entry.owner));
               if (rsp_mon.var_out !== want.entry.var_id)
                  report_mismatch("var_out", rsp_mon.var_out, want.entry.var_id);
               if (rsp_mon.word_a_out !== want.entry.word_a)
                  report_mismatch("word_a_out", rsp_mon.word_a_out, want.entry.word_a);
               if (rsp_mon.word_b_out !== want.entry.word_b)
                  report_mismatch("word_b_out", rsp_mon.word_b_out, want.entry.word_b);
               if (rsp_mon.kind_out !== want.entry.kind)
                  report_mismatch("kind_out", 32'(rsp_mon.kind_out), 32'(want.entry.kind));
               if (rsp_mon.match_count !== want.match_count)
                  report_mismatch("match_count", 32'(rsp_mon.match_count),
                                  32'(want.match_count));
            end
            beat_num++;
         end
         if (req_mon.valid && req_mon.ready) begin
            req_e.owner  = req_mon.owner_id;
            req_e.var_id = req_mon.var_id;
            req_e.word_a = req_mon.word_a;
            req_e.word_b = req_mon.word_b;
            req_e.kind   = req_mon.kind;
            owed_results.push_back(table_apply(req_mon.mode, req_e, req_mon.slot_index));
         end
      end
      results_owed = owed_results.size();
   end

endmodule

// ----- verif/tb_keyed_slot_table_unit.sv -----
`timescale 1ns / 100ps

module tb_keyed_slot_table_unit import kst_pkg::*; ();

   localparam int SLOT_COUNT = 64;

   logic clock;
   logic reset;
   bit   idle_on;
   int   stall_left;
   int   fail_count;
   int   results_owed;

   kst_req_if req_if ();
   kst_rsp_if rsp_if ();

   keyed_slot_table_unit #(.SLOT_COUNT(SLOT_COUNT)) DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_if),
      .rsp_bus (rsp_if)
   );

   kst_table_checker #(.SLOT_COUNT(SLOT_COUNT)) table_check (
      .clock        (clock),
      .reset        (reset),
      .req_mon      (req_if),
      .rsp_mon      (rsp_if),
      .fail_count   (fail_count),
      .results_owed (results_owed)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #6_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   // result side back-pressure
   initial begin
      rsp_if.ready = 1'b0;
      stall_left   = 0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            stall_left--;
            rsp_if.ready = 1'b0;
         end else if (idle_on && $urandom_range(0, 7) == 0) begin
            stall_left   = $urandom_range(0, 13);
            rsp_if.ready = 1'b0;
         end else begin
            rsp_if.ready = 1'b1;
         end
      end
   end

   task send_request(input logic [MODE_W-1:0] mode, input logic [OWNER_W-1:0] owner,
                     input logic [VAR_W-1:0] var_id, input logic [WORD_W-1:0] wa,
                     input logic [WORD_W-1:0] wb, input logic [KIND_W-1:0] kind,
                     input logic [SIDX_W-1:0] sidx);
      int gap;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 14);
         repeat (gap) begin
            @(negedge clock);
            req_if.valid = 1'b0;
         end
      end
      @(negedge clock);
      req_if.mode       = mode;
      req_if.owner_id   = owner;
      req_if.var_id     = var_id;
      req_if.word_a     = wa;
      req_if.word_b     = wb;
      req_if.kind       = kind;
      req_if.slot_index = sidx;
      req_if.valid      = 1'b1;
      do @(posedge clock); while (!req_if.ready);
   endtask

   // profile 0 fills the table, 1 drains it, 2 mixes
   task send_random(input int profile);
      logic [MODE_W-1:0]  mode;
      logic [OWNER_W-1:0] owner;
      logic [VAR_W-1:0]   var_id;
      logic [KIND_W-1:0]  kind;
      int pick, t_ins, t_look, t_first, t_free;
      case (profile)
         0:       begin t_ins = 60; t_look = 72; t_first = 80; t_free = 88; end
         1:       begin t_ins = 20; t_look = 35; t_first = 45; t_free = 85; end
         default: begin t_ins = 35; t_look = 55; t_first = 65; t_free = 80; end
      endcase
      pick = $urandom_range(0, 99);
      if (pick < t_ins)        mode = MODE_INSERT;
      else if (pick < t_look)  mode = MODE_LOOKUP;
      else if (pick < t_first) mode = MODE_FIRST;
      else if (pick < t_free)  mode = MODE_FREE;
      else if (pick < 97)      mode = MODE_COUNT;
      else                     mode = MODE_COUNT + MODE_W'($urandom_range(1, 3));
      // small key pools so searches hit
      if ($urandom_range(0, 3) == 0) owner = OWNER_W'($urandom);
      else                           owner = OWNER_W'($urandom_range(0, 3));
      pick = $urandom_range(0, 19);
      if (pick == 0)     var_id = '0;
      else if (pick < 6) var_id = $urandom;
      else               var_id = VAR_W'($urandom_range(1, 6));
      if ($urandom_range(0, 15) == 0) kind = '0;
      else                            kind = KIND_W'($urandom);
      send_request(mode, owner, var_id, $urandom, $urandom, kind, SIDX_W'($urandom));
   endtask

   initial begin
      reset             = 1'b1;
      idle_on           = 1'b1;
      req_if.valid      = 1'b0;
      req_if.mode       = MODE_INSERT;
      req_if.owner_id   = '0;
      req_if.var_id     = '0;
      req_if.word_a     = '0;
      req_if.word_b     = '0;
      req_if.kind       = '0;
      req_if.slot_index = '0;
      repeat (7) @(negedge clock);
      reset = 1'b0;

      // empty table: owner zero matches every slot
      send_request(MODE_COUNT,  8'h00, 32'h0, 32'h0, 32'h0, 16'h0, 6'd0);
      send_request(MODE_LOOKUP, 8'h00, 32'h0, 32'h0, 32'h0, 16'h0, 6'd0);
      send_request(MODE_FIRST,  8'h00, 32'h0, 32'h0, 32'h0, 16'h0, 6'd0);
      // zero var / zero kind rejected
      send_request(MODE_INSERT, 8'h12, 32'h0, 32'h1, 32'h2, 16'h3, 6'd0);
      send_request(MODE_INSERT, 8'h12, 32'h5, 32'h1, 32'h2, 16'h0, 6'd0);
      send_request(MODE_INSERT, 8'hFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                   16'hFFFF, 6'd63);
      send_request(MODE_INSERT, 8'h00, 32'h1, 32'h8000_0000, 32'h7FFF_FFFF, 16'h1, 6'd0);
      send_request(MODE_INSERT, 8'h01, 32'h1234_5678, 32'hFFFF_FFFF, 32'h0, 16'h8000, 6'd0);
      send_request(MODE_LOOKUP, 8'hFF, 32'hFFFF_FFFF, 32'h0, 32'h0, 16'h0, 6'd0);
      send_request(MODE_LOOKUP, 8'h01, 32'h1234_5679, 32'h0, 32'h0, 16'h0, 6'd0);
      send_request(MODE_FIRST,  8'h01, 32'h0, 32'h0, 32'h0, 16'h0, 6'd0);
      send_request(MODE_FIRST,  8'h55, 32'h0, 32'h0, 32'h0, 16'h0, 6'd0);
      send_request(MODE_COUNT,  8'hFF, 32'h0, 32'h0, 32'h0, 16'h0, 6'd0);
      send_request(MODE_COUNT,  8'h00, 32'h0, 32'h0, 32'h0, 16'h0, 6'd0);
      send_request(MODE_FREE,   8'h00, 32'h0, 32'h0, 32'h0, 16'h0, 6'd1);
      // free of an empty slot
      send_request(MODE_FREE,   8'h00, 32'h0, 32'h0, 32'h0, 16'h0, 6'd1);
      send_request(MODE_FREE,   8'h00, 32'h0, 32'h0, 32'h0, 16'h0, 6'd63);
      send_request(MODE_LOOKUP, 8'h00, 32'h0, 32'h0, 32'h0, 16'h0, 6'd0);
      // unused modes
      send_request(MODE_COUNT + 3'd1, 8'h01, 32'h1, 32'h1, 32'h1, 16'h1, 6'd2);
      send_request(MODE_COUNT + 3'd2, 8'h01, 32'h1, 32'h1, 32'h1, 16'h1, 6'd2);
      send_request(MODE_COUNT + 3'd3, 8'h01, 32'h1, 32'h1, 32'h1, 16'h1, 6'd2);
      send_request(MODE_INSERT, 8'hA5, 32'h0000_0001, 32'h5A5A_5A5A, 32'hA5A5_A5A5,
                   16'h0001, 6'd0);

      for (int ph = 0; ph < 10; ph++) begin
         idle_on = (ph != 9) && (ph % 4 != 2);
         for (int n = 0; n < 100; n++) send_random(ph % 3);
      end

      @(negedge clock);
      req_if.valid = 1'b0;
      while (results_owed != 0) @(negedge clock);
      repeat (SLOT_COUNT + 8) @(negedge clock);
      if (fail_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
design/kst_pkg.sv
design/kst_if.sv
design/kst_ram.sv
design/kst_match.sv
design/keyed_slot_table_unit.sv
verif/kst_table_checker.sv
verif/tb_keyed_slot_table_unit.sv
